[src/rshd_pkg.sv]
// shared types, constants and the segment table of the display counter
package rshd_pkg;

  localparam int unsigned ValW   = 16;
  localparam int unsigned TallyW = 5;
  localparam int unsigned RateW  = 4;
  localparam int unsigned SegW   = 7;
  localparam int unsigned NibW   = 4;

  localparam logic [ValW-1:0]   CountReset = 16'h8AFE;
  localparam logic [ValW-1:0]   DecLimit   = 16'd9999;
  localparam logic [RateW-1:0]  RateReset  = 4'd1;
  localparam logic [7:0]        CharHex    = 8'h68;
  localparam logic [7:0]        CharDec    = 8'h64;
  localparam logic [7:0]        CharZero   = 8'd48;
  localparam logic [7:0]        CharNine   = 8'd57;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_CONV = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  // gfedcba, active high
  function automatic logic [SegW-1:0] seg_of(input logic [NibW-1:0] nib);
    logic [SegW-1:0] s;
    case (nib)
      4'h0: s = 7'h3F;
      4'h1: s = 7'h06;
      4'h2: s = 7'h5B;
      4'h3: s = 7'h4F;
      4'h4: s = 7'h66;
      4'h5: s = 7'h6D;
      4'h6: s = 7'h7D;
      4'h7: s = 7'h07;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h6F;
      4'hA: s = 7'h77;
      4'hB: s = 7'h7C;
      4'hC: s = 7'h39;
      4'hD: s = 7'h5E;
      4'hE: s = 7'h79;
      4'hF: s = 7'h71;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

[src/rshd_mod.sv]
// bit-serial remainder unit: tick tally modulo rate divisor, one bit per cycle
module rshd_mod
  import rshd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TallyW-1:0] dividend_i,
  input  logic [RateW-1:0]  divisor_i,
  output unit_stat_t        stat_o,
  output logic              rem_zero_o
);

  localparam int unsigned CntW = $clog2(TallyW);

  logic [TallyW-1:0] dvd_q;
  logic [RateW-1:0]  div_q;
  logic [RateW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q;
  logic [RateW:0]    trial;
  logic              fits;
  logic              last;

  assign trial = {rem_q, dvd_q[TallyW-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign last  = cnt_q == CntW'(TallyW - 1);

  always_comb begin
    if (fits) begin
      rem_d = RateW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[RateW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TallyW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign stat_o     = '{busy: busy_q, done: done_q};
  assign rem_zero_o = rem_q == '0;

endmodule

[src/rshd_bcd.sv]
// bit-serial binary to bcd converter (shift and add three), low four digits kept
module rshd_bcd
  import rshd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ValW-1:0] value_i,
  output unit_stat_t      stat_o,
  output logic [ValW-1:0] bcd_o
);

  localparam int unsigned CntW   = $clog2(ValW);
  localparam int unsigned Digits = ValW / NibW;

  logic [ValW-1:0] bin_q;
  logic [ValW-1:0] bcd_q;
  logic [ValW-1:0] adj;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic            last;

  assign last = cnt_q == CntW'(ValW - 1);

  // digits above the fourth only ever move upwards, so they are simply dropped
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      if (bcd_q[i*NibW +: NibW] >= 4'd5) begin
        adj[i*NibW +: NibW] = bcd_q[i*NibW +: NibW] + 4'd3;
      end else begin
        adj[i*NibW +: NibW] = bcd_q[i*NibW +: NibW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[ValW-2:0], 1'b0};
      bcd_q <= {adj[ValW-2:0], bin_q[ValW-1]};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign bcd_o  = bcd_q;

endmodule

[src/rate_scaled_hex_dec_display_counter_top.sv]
// a character beat goes through the serial bcd converter, a tick beat through the serial
// remainder unit and then the converter; one beat at a time, the 16-step converter (and
// for ticks the 5-step remainder unit) finishing before the next beat is taken in
// a finished result waits in the output register while the next beat is taken in; a second
// finished result holds off the input until the first one is taken
// reset: asynchronous, active low; decimal mode, divisor 1, tally 0, counter 0x8afe
module rate_scaled_hex_dec_display_counter_top
  import rshd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [7:0]        rx_char_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SegW-1:0]   seg_digit3_o,
  output logic [SegW-1:0]   seg_digit2_o,
  output logic [SegW-1:0]   seg_digit1_o,
  output logic [SegW-1:0]   seg_digit0_o,
  output logic [ValW-1:0]   shown_value_o,
  output logic              hex_mode_o,
  output logic [RateW-1:0]  rate_scale_o
);

  state_e              state_q, state_d;
  logic                hex_q;
  logic [RateW-1:0]    rate_q;
  logic [TallyW-1:0]   tally_q;
  logic [ValW-1:0]     count_q;
  logic [ValW-1:0]     count_inc;
  logic                conv_start_q;
  logic                out_valid_q;
  logic                in_fire;
  logic                mod_start;
  logic [TallyW-1:0]   tally_next;
  logic                rem_zero;
  logic                out_load;
  unit_stat_t          mod_stat, bcd_stat;
  logic [ValW-1:0]     bcd_digits;
  logic [ValW-1:0]     digits;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_fire    = in_valid_i && in_ready_o;
  assign tally_next = tally_q + TallyW'(1);
  assign mod_start  = in_fire && func_i;
  assign count_inc  = count_q + ValW'(1);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  rshd_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (tally_next),
    .divisor_i  (rate_q),
    .stat_o     (mod_stat),
    .rem_zero_o (rem_zero)
  );

  rshd_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start_q),
    .value_i (count_q),
    .stat_o  (bcd_stat),
    .bcd_o   (bcd_digits)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = func_i ? ST_MOD : ST_CONV;
        end
      end
      ST_MOD: begin
        if (mod_stat.done) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hex_q        <= 1'b0;
      rate_q       <= RateReset;
      tally_q      <= '0;
      count_q      <= CountReset;
      conv_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      conv_start_q <= (in_fire && !func_i) || ((state_q == ST_MOD) && mod_stat.done);
      if (in_fire) begin
        if (func_i) begin
          tally_q <= tally_next;
        end else if (rx_char_i == CharHex) begin
          hex_q <= 1'b1;
        end else if (rx_char_i == CharDec) begin
          hex_q <= 1'b0;
        end else if (rx_char_i >= CharZero && rx_char_i <= CharNine) begin
          // low nibble of an ascii digit is the digit itself
          rate_q <= rx_char_i[RateW-1:0] + RateW'(1);
        end
      end
      if ((state_q == ST_MOD) && mod_stat.done && rem_zero) begin
        tally_q <= '0;
        if (!hex_q && count_inc > DecLimit) begin
          count_q <= '0;
        end else begin
          count_q <= count_inc;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign digits = hex_q ? count_q : bcd_digits;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      seg_digit3_o  <= seg_of(digits[4*NibW-1 -: NibW]);
      seg_digit2_o  <= seg_of(digits[3*NibW-1 -: NibW]);
      seg_digit1_o  <= seg_of(digits[2*NibW-1 -: NibW]);
      seg_digit0_o  <= seg_of(digits[NibW-1:0]);
      shown_value_o <= count_q;
      hex_mode_o    <= hex_q;
      rate_scale_o  <= rate_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!mod_stat.busy && !bcd_stat.busy))
    else $error("serial unit busy while taking a beat");

  a_mod_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_stat.done |-> state_q == ST_MOD)
    else $error("remainder result outside its state");

  a_bcd_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcd_stat.done |-> state_q == ST_CONV)
    else $error("conversion result outside its state");

  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rate_q != '0) && (rate_q <= RateW'(10)))
    else $error("rate divisor out of range");

endmodule

[test/tb_rate_scaled_hex_dec_display_counter_top.sv]
// testbench of the rate scaled hex/decimal display counter with predictor and scoreboard
`timescale 1ns / 1ps

module tb_rate_scaled_hex_dec_display_counter_top
  import rshd_pkg::*;
();

  localparam logic FuncChar = 1'b0;
  localparam logic FuncTick = 1'b1;
  localparam int unsigned RandItems  = 1630;
  localparam int unsigned CalmItems  = 120;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned LongHold   = 400;

  localparam logic [SegW-1:0] SegLut [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
  };

  typedef struct {
    logic       is_tick;
    logic [7:0] ch;
  } beat_t;

  typedef struct {
    logic [SegW-1:0]  seg3;
    logic [SegW-1:0]  seg2;
    logic [SegW-1:0]  seg1;
    logic [SegW-1:0]  seg0;
    logic [ValW-1:0]  value;
    logic             hex;
    logic [RateW-1:0] rate;
  } display_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              func = FuncChar;
  logic [7:0]        rx_char = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SegW-1:0]   seg_digit3, seg_digit2, seg_digit1, seg_digit0;
  logic [ValW-1:0]   shown_value;
  logic              hex_mode;
  logic [RateW-1:0]  rate_scale;

  beat_t    stim_q[$];
  display_t shown_q[$];

  // predictor state
  logic              hex_sel = 1'b0;
  logic [RateW-1:0]  divisor = RateReset;
  logic [TallyW-1:0] tally = '0;
  logic [ValW-1:0]   counter = CountReset;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  logic        calm = 1'b0;
  logic        send_lively = 1'b1;
  logic        recv_lively = 1'b1;
  logic        long_hold_done = 1'b0;

  rate_scaled_hex_dec_display_counter_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .rx_char_i     (rx_char),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .seg_digit3_o  (seg_digit3),
    .seg_digit2_o  (seg_digit2),
    .seg_digit1_o  (seg_digit1),
    .seg_digit0_o  (seg_digit0),
    .shown_value_o (shown_value),
    .hex_mode_o    (hex_mode),
    .rate_scale_o  (rate_scale)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // advances the counter state by one beat and returns what the display shows
  function automatic display_t next_display(input logic is_tick, input logic [7:0] ch);
    display_t        d;
    int unsigned     v;
    logic [RateW-1:0] div;
    logic [NibW-1:0] dig [4];
    if (!is_tick) begin
      if (ch == CharHex) hex_sel = 1'b1;
      else if (ch == CharDec) hex_sel = 1'b0;
      else if (ch >= CharZero && ch <= CharNine) divisor = RateW'(ch - CharZero + 8'd1);
    end else begin
      div = (divisor == '0) ? RateW'(1) : divisor;
      tally = tally + 1'b1;
      if (tally % div == 0) begin
        counter = counter + 1'b1;
        if (!hex_sel && counter > DecLimit) counter = '0;
        tally = '0;
      end
    end
    v = counter;
    for (int i = 0; i < 4; i++) begin
      if (hex_sel) begin
        dig[i] = NibW'(v & 4'hF);
        v = v >> 4;
      end else begin
        dig[i] = NibW'(v % 10);
        v = v / 10;
      end
    end
    d.seg3  = SegLut[dig[3]];
    d.seg2  = SegLut[dig[2]];
    d.seg1  = SegLut[dig[1]];
    d.seg0  = SegLut[dig[0]];
    d.value = counter;
    d.hex   = hex_sel;
    d.rate  = divisor;
    return d;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  function automatic beat_t char_beat(input logic [7:0] ch);
    beat_t b;
    b.is_tick = FuncChar;
    b.ch      = ch;
    return b;
  endfunction

  function automatic beat_t tick_beat();
    beat_t b;
    b.is_tick = FuncTick;
    b.ch      = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // sender
  always @(posedge clk_i) begin : driver
    beat_t b;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) shown_q.push_back(next_display(func, rx_char));
      calm <= (stim_q.size() < CalmItems);
      if ($urandom_range(0, 127) == 0) send_lively <= ~send_lively;
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && send_lively && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          b = stim_q.pop_front();
          func     <= b.is_tick;
          rx_char  <= b.ch;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off so the block backs up into the sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 127) == 0) recv_lively <= ~recv_lively;
      if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
        long_hold_done <= 1'b1;
        recv_gap       <= LongHold - 1;
        out_ready      <= 1'b0;
      end else if (!calm && recv_lively && $urandom_range(0, 5) == 0) begin
        recv_gap  <= $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin : monitor
    display_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (shown_q.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, value %0d", $time, shown_value);
      end else begin
        want = shown_q.pop_front();
        check_field("seg_digit3", want.seg3, seg_digit3);
        check_field("seg_digit2", want.seg2, seg_digit2);
        check_field("seg_digit1", want.seg1, seg_digit1);
        check_field("seg_digit0", want.seg0, seg_digit0);
        check_field("shown_value", want.value, shown_value);
        check_field("hex_mode", want.hex, hex_mode);
        check_field("rate_scale", want.rate, rate_scale);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_rate_scaled_hex_dec_display_counter_top failed");
      $finish;
    end
  end

  initial begin : main
    int unsigned r;
    // ignored bytes first: reset value shown as its low decimal digits
    stim_q.push_back(char_beat(8'h00));
    stim_q.push_back(char_beat(8'hFF));
    stim_q.push_back(char_beat(CharZero - 8'd1));
    stim_q.push_back(char_beat(CharNine + 8'd1));
    stim_q.push_back(char_beat(CharHex));
    stim_q.push_back(tick_beat());
    stim_q.push_back(char_beat(CharHex ^ 8'h20));
    stim_q.push_back(char_beat(CharDec ^ 8'h20));
    // back to decimal above the limit, next tick wraps to zero
    stim_q.push_back(char_beat(CharDec));
    stim_q.push_back(tick_beat());
    stim_q.push_back(char_beat(CharNine));
    for (int i = 0; i < 10; i++) stim_q.push_back(tick_beat());
    stim_q.push_back(char_beat(CharZero));
    stim_q.push_back(tick_beat());
    stim_q.push_back(char_beat(CharHex));
    stim_q.push_back(tick_beat());
    stim_q.push_back(char_beat(CharDec));
    for (int i = 0; i < RandItems; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) stim_q.push_back(tick_beat());
      else if (r < 75) stim_q.push_back(char_beat(CharZero + 8'($urandom_range(0, 9))));
      else if (r < 85) stim_q.push_back(char_beat($urandom_range(0, 1) ? CharHex : CharDec));
      else stim_q.push_back(char_beat(8'($urandom_range(0, 255))));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (stim_q.size() != 0 || in_valid || shown_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_rate_scaled_hex_dec_display_counter_top passed");
    end else begin
      $display("tb_rate_scaled_hex_dec_display_counter_top failed");
    end
    $finish;
  end

endmodule

[files.f]
src/rshd_pkg.sv
src/rshd_mod.sv
src/rshd_bcd.sv
src/rate_scaled_hex_dec_display_counter_top.sv
test/tb_rate_scaled_hex_dec_display_counter_top.sv
